// ===== hdl/hgma_pkg.sv =====
// shared types, constants and helpers of the height grid min/max accumulator
// no dependencies
package hgma_pkg;

    localparam int GRID_ROWS_DEF = 512;
    localparam int GRID_COLS_DEF = 512;

    localparam logic [15:0] INV_RES_RESET = 16'd256;

    // coordinate sums are held in Q.16 with room for the largest grid
    localparam int FRAC_W = 16;
    localparam int SUM_W  = 42;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic [1:0] KIND_LOW  = 2'd0;
    localparam logic [1:0] KIND_BOTH = 2'd1;
    localparam logic [1:0] KIND_HIGH = 2'd2;

    typedef struct packed {
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic [7:0]         height;
        logic               is_highest;
        logic               last;
    } result_t;

    typedef struct packed {
        logic mul_en;
        logic addr_en;
        logic idx_en;
    } map_ctrl_t;

    // integer part of a signed Q16.8 value, truncated toward zero
    function automatic logic signed [15:0] trunc_int(input logic signed [23:0] v);
        logic signed [15:0] f;
        f = v[23:8];
        if (v[23] && (v[7:0] != 8'd0))
        begin
            f = f + 16'sd1;
        end
        return f;
    endfunction

    // integer height limited to 1..255
    function automatic logic [7:0] clamp_height(input logic signed [23:0] v);
        logic [7:0] h;
        if (v[23])
        begin
            h = 8'd1;
        end
        else if (v[22:16] != 7'd0)
        begin
            h = 8'd255;
        end
        else if (v[15:8] == 8'd0)
        begin
            h = 8'd1;
        end
        else
        begin
            h = v[15:8];
        end
        return h;
    endfunction

endpackage

// ===== hdl/hgma_cell_ram.sv =====
// cell store: one write port, one read port, registered read data
// depends on nothing but its parameters
module hgma_cell_ram #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [23:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [23:0]   rdata
);

    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/hgma_cell_map.sv =====
// maps a scaled coordinate pair to a cell index over three registered steps
// depends on hgma_pkg
module hgma_cell_map #(
    parameter int GRID_ROWS = hgma_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = hgma_pkg::GRID_COLS_DEF,
    parameter int AW        = $clog2(GRID_ROWS * GRID_COLS)
) (
    input  logic                clk,
    input  hgma_pkg::map_ctrl_t ctrl,
    input  logic signed [23:0]  op_x,
    input  logic signed [23:0]  op_y,
    input  logic [15:0]         inv,
    output logic [AW-1:0]       idx,
    output logic                in_grid
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int SW = hgma_pkg::SUM_W;
    localparam int FW = hgma_pkg::FRAC_W;

    logic signed [40:0]  px_reg, py_reg;
    logic signed [SW-1:0] col_s, row_s;
    logic [RW-1:0]       row_reg;
    logic [CW-1:0]       col_reg;
    logic                in_grid_reg;
    logic [AW-1:0]       idx_reg;

    // inside test of one axis, truncation toward zero
    function automatic logic axis_ok(input logic signed [SW-1:0] s, input int dim);
        logic [SW-FW-1:0] hi;
        logic             ok;
        hi = s[SW-1:FW];
        if (s[SW-1])
        begin
            ok = (&hi) && (s[FW-1:0] != '0);
        end
        else
        begin
            ok = hi < (SW-FW)'(dim);
        end
        return ok;
    endfunction

    assign col_s = (SW'(GRID_COLS / 2) <<< FW) + SW'(px_reg);
    assign row_s = (SW'(GRID_ROWS / 2) <<< FW) - SW'(py_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            px_reg <= op_x * $signed({1'b0, inv});
            py_reg <= op_y * $signed({1'b0, inv});
        end
        if (ctrl.addr_en)
        begin
            in_grid_reg <= axis_ok(col_s, GRID_COLS) && axis_ok(row_s, GRID_ROWS);
            col_reg     <= col_s[SW-1] ? '0 : col_s[FW +: CW];
            row_reg     <= row_s[SW-1] ? '0 : row_s[FW +: RW];
        end
        if (ctrl.idx_en)
        begin
            idx_reg <= AW'(row_reg) * AW'(GRID_COLS) + AW'(col_reg);
        end
    end

    assign idx     = idx_reg;
    assign in_grid = in_grid_reg;

endmodule

// ===== hdl/hgma_out_queue.sv =====
// two-entry result queue between the update step and the output channel
// depends on hgma_pkg
module hgma_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              push_two,
    input  hgma_pkg::result_t e0,
    input  hgma_pkg::result_t e1,
    output logic              empty,
    output logic              out_valid,
    input  logic              out_ready,
    output hgma_pkg::result_t head
);

    hgma_pkg::result_t slot0_reg, slot1_reg;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign pop = out_valid && out_ready;

    // pushes only arrive while the queue is empty
    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = push_two ? 2'd2 : 2'd1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot0_reg <= e0;
            slot1_reg <= e1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign empty     = (count_reg == 2'd0);
    assign out_valid = !empty;
    assign head      = slot0_reg;

endmodule

// ===== hdl/height_grid_min_max_accumulator_unit.sv =====
// Elevation grid that bins point heights into per-cell min, count and max.
// Input stream: s_axis, tdata = x_coord, y_coord, z_height (Q16.8 each),
// tuser = mode, query_kind. An insert folds z into one cell and gives no
// result; a query reads one cell and gives zero, one or two results.
// Output stream: m_axis, tdata = cell_x, cell_y, height, tuser = is_highest,
// tlast marks the last result of a query.
// Configuration: cfg_valid/cfg_ready/cfg_data writes inv_resolution (Q8.8).
// Each item passes these steps from acceptance to write-back or to its results
// reaching the output queue: multiply, axis check, index multiply-add,
// memory read, update. The state machine holds one item at a time and returns
// to idle between items, so no new item is taken before the last one is done.
// The first result appears on m_axis in the cycle after the update step.
// After reset the memory is cleared one cell a cycle, all GRID_ROWS*GRID_COLS
// cells (262144 by default), while s_axis_tready stays low.
// Results wait in a two-entry queue while the receiver stalls; further items
// are accepted meanwhile, and a query waits at its update step until the
// queue has drained.
// depends on hgma_pkg, hgma_cell_ram, hgma_cell_map, hgma_out_queue
module height_grid_min_max_accumulator_unit #(
    parameter int GRID_ROWS = hgma_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = hgma_pkg::GRID_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // x_coord, y_coord, z_height
    input  logic [2:0]  s_axis_tuser,  // mode, query_kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // cell_x, cell_y, height
    output logic        m_axis_tuser,  // is_highest
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADDR = 3'd3;
    localparam logic [2:0] ST_IDX  = 3'd4;
    localparam logic [2:0] ST_RD   = 3'd5;
    localparam logic [2:0] ST_UPD  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [15:0]        inv_reg;

    logic               mode_reg;
    logic signed [23:0] x_reg, y_reg, z_reg;
    logic [1:0]         kind_reg;

    logic signed [15:0] qx, qy;
    logic signed [23:0] op_x, op_y;
    hgma_pkg::map_ctrl_t map_ctrl;
    logic [AW-1:0]      cell_idx;
    logic               in_grid;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [23:0]        ram_wdata, ram_rdata;

    logic [7:0]         z_val, lo, cnt, hi, new_lo, new_hi;

    logic               q_push, q_two, q_empty;
    hgma_pkg::result_t  q_e0, q_e1, q_head;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= hgma_pkg::INV_RES_RESET;
        end
        else if (cfg_valid)
        begin
            inv_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            x_reg    <= s_axis_tdata[23:0];
            y_reg    <= s_axis_tdata[47:24];
            z_reg    <= s_axis_tdata[71:48];
            mode_reg <= s_axis_tuser[0];
            kind_reg <= s_axis_tuser[2:1];
        end
    end

    // a query maps integer metres; scaling by 256 lets both share one path
    assign qx   = hgma_pkg::trunc_int(x_reg);
    assign qy   = hgma_pkg::trunc_int(y_reg);
    assign op_x = (mode_reg == hgma_pkg::MODE_QUERY) ? {qx, 8'h00} : x_reg;
    assign op_y = (mode_reg == hgma_pkg::MODE_QUERY) ? {qy, 8'h00} : y_reg;

    always_comb
    begin
        map_ctrl         = '0;
        map_ctrl.mul_en  = (state_reg == ST_MUL);
        map_ctrl.addr_en = (state_reg == ST_ADDR);
        map_ctrl.idx_en  = (state_reg == ST_IDX);
    end

    hgma_cell_map #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS),
        .AW(AW)
    ) u_map (
        .clk(clk),
        .ctrl(map_ctrl),
        .op_x(op_x),
        .op_y(op_y),
        .inv(inv_reg),
        .idx(cell_idx),
        .in_grid(in_grid)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_IDX;
            ST_IDX:  state_next = ST_RD;
            ST_RD:   state_next = ST_UPD;
            ST_UPD:
            begin
                if (mode_reg == hgma_pkg::MODE_INSERT || q_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign lo     = ram_rdata[7:0];
    assign cnt    = ram_rdata[15:8];
    assign hi     = ram_rdata[23:16];
    assign z_val  = hgma_pkg::clamp_height(z_reg);
    assign new_lo = (lo == 8'd0 || z_val < lo) ? z_val : lo;
    assign new_hi = (z_val > hi) ? z_val : hi;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cell_idx;
        ram_wdata = {new_hi, cnt + 8'd1, new_lo};
        if (state_reg == ST_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_UPD && mode_reg == hgma_pkg::MODE_INSERT && in_grid)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re = (state_reg == ST_RD);

    hgma_cell_ram #(
        .DEPTH(DEPTH),
        .AW(AW)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr(cell_idx),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        q_e0            = '0;
        q_e1            = '0;
        q_e0.cell_x     = qx;
        q_e0.cell_y     = qy;
        q_e1.cell_x     = qx;
        q_e1.cell_y     = qy;
        q_e1.height     = hi;
        q_e1.is_highest = 1'b1;
        q_e1.last       = 1'b1;
        q_two           = 1'b0;
        q_push          = (state_reg == ST_UPD) && (mode_reg == hgma_pkg::MODE_QUERY)
                          && q_empty && in_grid && (hi != 8'd0);
        case (kind_reg)
            hgma_pkg::KIND_LOW:
            begin
                q_e0.height     = lo;
                q_e0.is_highest = 1'b0;
                q_e0.last       = 1'b1;
            end
            hgma_pkg::KIND_BOTH:
            begin
                if (lo < hi)
                begin
                    q_e0.height     = lo;
                    q_e0.is_highest = 1'b0;
                    q_e0.last       = 1'b0;
                    q_two           = 1'b1;
                end
                else
                begin
                    q_e0.height     = hi;
                    q_e0.is_highest = 1'b1;
                    q_e0.last       = 1'b1;
                end
            end
            default:
            begin
                q_e0.height     = hi;
                q_e0.is_highest = 1'b1;
                q_e0.last       = 1'b1;
            end
        endcase
    end

    hgma_out_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_two(q_two),
        .e0(q_e0),
        .e1(q_e1),
        .empty(q_empty),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .head(q_head)
    );

    assign m_axis_tdata = {q_head.height, q_head.cell_y, q_head.cell_x};
    assign m_axis_tuser = q_head.is_highest;
    assign m_axis_tlast = q_head.last;

endmodule

// ===== hdl/hgma_checker.sv =====
// port-level checks of the height grid accumulator, bound to the top level
// depends on height_grid_min_max_accumulator_unit
module hgma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one item at a time: no accept right after an accept
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // the first of a pair is the minimum
    a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
        else $error("non-final result is not a minimum");

    // the second of a pair follows at once and is the maximum
    a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && m_axis_tlast && m_axis_tuser)
        else $error("pair not completed by a maximum");

    // an empty cell never produces a result
    a_height_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:32] != 8'd0)
        else $error("result with zero height");

endmodule

bind height_grid_min_max_accumulator_unit hgma_checker u_hgma_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);

// ===== sim/tb_top.sv =====
// testbench for the height grid min/max accumulator: random and directed point streams
// with a self-contained cell store predictor and an in-order result scoreboard
// depends on hgma_pkg and height_grid_min_max_accumulator_unit
`timescale 1ns / 100ps

module tb_top;

    localparam int          PHASES           = 7;
    localparam int          PRESSURE_PHASE   = 4;
    localparam int          RANDOM_PER_PHASE = 58;
    localparam int          HOT_POINTS       = 8;
    localparam int          HOLD_CYCLES      = 300;
    localparam int          DRAIN_CYCLES     = 32;
    localparam int unsigned CYCLE_LIMIT      = 1000000;
    localparam logic [1:0]  KIND_HIGH_ALIAS  = 2'd3;  // unused code, behaves as highest

    typedef struct {
        logic               mode;
        logic signed [23:0] x_coord;
        logic signed [23:0] y_coord;
        logic signed [23:0] z_height;
        logic [1:0]         query_kind;
    } point_item_t;

    class grid_scoreboard;
        bit [23:0]         cells [int unsigned];  // {min, count, max}
        logic [15:0]       inv_res;
        hgma_pkg::result_t expected_q[$];
        int                errors;

        function new();
            inv_res = hgma_pkg::INV_RES_RESET;
            errors  = 0;
        endfunction

        function void set_inv(logic [15:0] v);
            inv_res = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit on_grid(longint row, longint col);
            return row >= 0 && col >= 0 && row < hgma_pkg::GRID_ROWS_DEF
                   && col < hgma_pkg::GRID_COLS_DEF;
        endfunction

        function void add_result(longint xi, longint yi, bit [7:0] h, bit hi_flag, bit last);
            hgma_pkg::result_t r;
            r.cell_x     = xi[15:0];
            r.cell_y     = yi[15:0];
            r.height     = h;
            r.is_highest = hi_flag;
            r.last       = last;
            expected_q   = {expected_q, r};
        endfunction

        // fold one accepted transaction into the cell store, queue what it yields
        function void note_item(point_item_t it);
            longint      x, y, inv, col, row, zi, xi, yi;
            int unsigned idx;
            bit [23:0]   c;
            bit [7:0]    lo, cnt, hi, z;
            x   = it.x_coord;
            y   = it.y_coord;
            inv = inv_res;
            if (it.mode == hgma_pkg::MODE_INSERT)
            begin
                col = (longint'(hgma_pkg::GRID_COLS_DEF / 2) * 65536 + x * inv) / 65536;
                row = (longint'(hgma_pkg::GRID_ROWS_DEF / 2) * 65536 - y * inv) / 65536;
                if (!on_grid(row, col))
                begin
                    return;
                end
                zi = longint'(it.z_height) / 256;
                if (zi < 1)
                begin
                    zi = 1;
                end
                if (zi > 255)
                begin
                    zi = 255;
                end
                z   = zi[7:0];
                idx = 32'(row * hgma_pkg::GRID_COLS_DEF + col);
                c   = cells.exists(idx) ? cells[idx] : 24'd0;
                {lo, cnt, hi} = c;
                if (lo == 0 || z < lo)
                begin
                    lo = z;
                end
                if (z > hi)
                begin
                    hi = z;
                end
                cnt = cnt + 8'd1;
                cells[idx] = {lo, cnt, hi};
            end
            else
            begin
                xi  = x / 256;
                yi  = y / 256;
                col = (longint'(hgma_pkg::GRID_COLS_DEF / 2) * 256 + xi * inv) / 256;
                row = (longint'(hgma_pkg::GRID_ROWS_DEF / 2) * 256 - yi * inv) / 256;
                if (!on_grid(row, col))
                begin
                    return;
                end
                idx = 32'(row * hgma_pkg::GRID_COLS_DEF + col);
                c   = cells.exists(idx) ? cells[idx] : 24'd0;
                {lo, cnt, hi} = c;
                if (hi == 0)
                begin
                    return;
                end
                if (it.query_kind == hgma_pkg::KIND_LOW)
                begin
                    add_result(xi, yi, lo, 1'b0, 1'b1);
                end
                else if (it.query_kind == hgma_pkg::KIND_BOTH && lo < hi)
                begin
                    add_result(xi, yi, lo, 1'b0, 1'b0);
                    add_result(xi, yi, hi, 1'b1, 1'b1);
                end
                else
                begin
                    add_result(xi, yi, hi, 1'b1, 1'b1);
                end
            end
        endfunction

        function void compare_field(string name, longint e, longint g);
            if (e != g)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, g);
                errors++;
            end
        endfunction

        function void check_result(hgma_pkg::result_t got);
            hgma_pkg::result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("cell_x", e.cell_x, got.cell_x);
            compare_field("cell_y", e.cell_y, got.cell_y);
            compare_field("height", e.height, got.height);
            compare_field("is_highest", e.is_highest, got.is_highest);
            compare_field("last", e.last, got.last);
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;  // x_coord, y_coord, z_height
    logic [2:0]  s_axis_tuser  = '0;  // mode, query_kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // cell_x, cell_y, height
    logic        m_axis_tuser;        // is_highest
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = '0;

    grid_scoreboard sb;
    int             send_gap_pct   = 0;
    int             recv_stall_pct = 0;
    bit             pressure_on    = 1'b0;
    int             hot_x [HOT_POINTS];
    int             hot_y [HOT_POINTS];
    int unsigned    cycle_count    = 0;

    height_grid_min_max_accumulator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge clk)
    begin
        if (pressure_on && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(hgma_pkg::result_t'({m_axis_tdata[15:0], m_axis_tdata[31:16],
                                                 m_axis_tdata[39:32], m_axis_tuser,
                                                 m_axis_tlast}));
        end
    end

    function automatic point_item_t mk_point(logic mode, int x, int y, int z, logic [1:0] kind);
        point_item_t it;
        it.mode       = mode;
        it.x_coord    = 24'(x);
        it.y_coord    = 24'(y);
        it.z_height   = 24'(z);
        it.query_kind = kind;
        return it;
    endfunction

    // Q16.8 coordinate whose integer part is m
    function automatic logic signed [23:0] coord_near(int m);
        int frac;
        frac = $urandom_range(255);
        if (m < 0 || (m == 0 && $urandom_range(1) == 1))
        begin
            return 24'(m * 256 - frac);
        end
        return 24'(m * 256 + frac);
    endfunction

    function automatic logic signed [23:0] random_height();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return 24'($urandom());
        end
        if (sel == 1)
        begin
            return 24'(-int'($urandom_range(2000)));
        end
        return 24'($urandom_range(300 * 256));
    endfunction

    // mostly traffic on a few hot cells so queries find data, some noise
    function automatic point_item_t random_point();
        point_item_t it;
        int          sel;
        int          k;
        sel           = $urandom_range(99);
        k             = $urandom_range(HOT_POINTS - 1);
        it.x_coord    = coord_near(hot_x[k]);
        it.y_coord    = coord_near(hot_y[k]);
        it.z_height   = random_height();
        it.query_kind = 2'($urandom_range(3));
        if (sel < 55)
        begin
            it.mode = hgma_pkg::MODE_INSERT;
        end
        else if (sel < 90)
        begin
            it.mode = hgma_pkg::MODE_QUERY;
        end
        else
        begin
            it.mode     = 1'($urandom_range(1));
            it.x_coord  = 24'($urandom());
            it.y_coord  = 24'($urandom());
            it.z_height = 24'($urandom());
        end
        return it;
    endfunction

    // metre positions that land on the grid at the current resolution
    task automatic pick_hot_points(input logic [15:0] inv);
        int lim;
        lim = (inv == 0) ? 32767 : 65535 / inv;
        if (lim > 32767)
        begin
            lim = 32767;
        end
        for (int k = 0; k < HOT_POINTS; k++)
        begin
            hot_x[k] = int'($urandom_range(2 * lim)) - lim;
            hot_y[k] = int'($urandom_range(2 * lim)) - lim;
        end
    endtask

    task automatic send_point(input point_item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.z_height, it.y_coord, it.x_coord};
        s_axis_tuser  <= {it.query_kind, it.mode};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_item(it);
    endtask

    task automatic write_inv(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sb.set_inv(v);
    endtask

    // inserts give no result, so allow the pipeline to finish writing back
    task automatic drain_and_wait();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // edge cases at one cell per metre
    task automatic run_directed();
        send_point(mk_point(hgma_pkg::MODE_QUERY, 0, 0, 0, hgma_pkg::KIND_BOTH));  // empty cell
        send_point(mk_point(hgma_pkg::MODE_INSERT, 0, 0, 0, hgma_pkg::KIND_LOW));  // zero height
        send_point(mk_point(hgma_pkg::MODE_INSERT, 128, -128, -8388608,
                            hgma_pkg::KIND_LOW));                                  // negative height
        send_point(mk_point(hgma_pkg::MODE_INSERT, 0, 0, 8388607,
                            hgma_pkg::KIND_LOW));                                  // saturates
        send_point(mk_point(hgma_pkg::MODE_INSERT, 0, 0, 5 * 256 + 128, hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_QUERY, 0, 0, 0, hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_QUERY, 0, 0, 0, hgma_pkg::KIND_BOTH));
        send_point(mk_point(hgma_pkg::MODE_QUERY, 0, 0, 0, hgma_pkg::KIND_HIGH));
        send_point(mk_point(hgma_pkg::MODE_QUERY, 0, 0, 0, KIND_HIGH_ALIAS));
        send_point(mk_point(hgma_pkg::MODE_INSERT, 10 * 256, 10 * 256, 7 * 256,
                            hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_QUERY, 10 * 256, 10 * 256, 0,
                            hgma_pkg::KIND_BOTH));                                 // min equals max
        send_point(mk_point(hgma_pkg::MODE_INSERT, -256 * 256, 256 * 256, 42 * 256,
                            hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_QUERY, -256 * 256 - 100, 256 * 256 + 50, 0,
                            hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_INSERT, 255 * 256 + 255, -255 * 256 - 255, 200 * 256,
                            hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_QUERY, 255 * 256 + 255, -255 * 256 - 255, 0,
                            hgma_pkg::KIND_HIGH));
        send_point(mk_point(hgma_pkg::MODE_INSERT, 256 * 256, 0, 3 * 256,
                            hgma_pkg::KIND_LOW));                                  // past last column
        send_point(mk_point(hgma_pkg::MODE_QUERY, 256 * 256, 0, 0, hgma_pkg::KIND_LOW));
        // half a cell left of column 0 truncates back into it
        send_point(mk_point(hgma_pkg::MODE_INSERT, -256 * 256 - 128, 0, 9 * 256,
                            hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_QUERY, -256 * 256 - 128, 0, 0, hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_INSERT, -257 * 256, 0, 11 * 256, hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_INSERT, -8388608, 8388607, 256, hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_QUERY, -8388608, 8388607, 0, hgma_pkg::KIND_LOW));
        send_point(mk_point(hgma_pkg::MODE_QUERY, 8388607, -8388608, 0, hgma_pkg::KIND_BOTH));
    endtask

    initial
    begin
        logic [15:0] inv;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_gap_pct = 57; recv_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_stall_pct = 57; end
                default: begin send_gap_pct = 33; recv_stall_pct = 33; end
            endcase
            case (p)
                1:       inv = 16'd1;
                2:       inv = 16'd65535;
                3:       inv = 16'd0;       // every point lands on the centre cell
                4:       inv = 16'($urandom_range(2, 65534));
                5:       inv = 16'd256;
                default: inv = 16'd128;
            endcase
            if (p > 0)
            begin
                write_inv(inv);
            end
            pick_hot_points(sb.inv_res);
            pressure_on = (p == PRESSURE_PHASE);
            if (p == 0)
            begin
                run_directed();
            end
            repeat (RANDOM_PER_PHASE) send_point(random_point());
            s_axis_tvalid <= 1'b0;
            drain_and_wait();
        end
        if (sb.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
